// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, skipped while reset is asserted.
`define CHK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check on clk, active through reset as well.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gtr_pkg.sv
package gtr_pkg;

  localparam int STORE_AW    = 12;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 6;
  localparam int XY_W        = 10;
  localparam int FIFO_W      = 16;
  localparam int FIFO_CNT_W  = 5;

  localparam logic [COL_W-1:0] COLUMNS_RST = 7'd79;
  localparam logic [ROW_W-1:0] ROWS_RST    = 6'd28;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  // Q8 color coefficients
  localparam logic [15:0] Y_R   = 16'd66;
  localparam logic [15:0] Y_G   = 16'd129;
  localparam logic [15:0] Y_B   = 16'd25;
  localparam logic [15:0] CB_R  = 16'd38;
  localparam logic [15:0] CB_G  = 16'd74;
  localparam logic [15:0] CB_B  = 16'd112;
  localparam logic [15:0] CR_R  = 16'd112;
  localparam logic [15:0] CR_G  = 16'd94;
  localparam logic [15:0] CR_B  = 16'd18;
  localparam logic [7:0]  Y_OFS = 8'd16;
  localparam logic [15:0] C_BIAS = 16'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_COLOR,
    ST_RUN
  } gtr_state_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } gtr_ycc_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] cnt;
    logic [1:0]            head;
  } gtr_fifo_stat_t;

endpackage

// File: src/glyph_to_ycbcr_renderer.sv
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    in_tdata, in_tuser (operation)
// out_      master     out_tvalid/out_tready  out_tdata, out_tlast (last pair)
// cfg_      slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A load request, a carriage return or a dropped character is taken in ST_IDLE alone; a newline
// also passes through ST_NORM. A drawn character goes through accept, row setup, three color
// steps and the store read, then emits one pixel pair a cycle while the output is not stalled,
// from the bit buffer, which the single glyph store read port refills a byte at a time.
// A cursor row at or above the row count is reduced in ST_NORM by subtraction. Reset clears
// the control registers only. out_tready low holds the output register and pauses the walk.
module glyph_to_ycbcr_renderer #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata, low bit up: char_code[7:0], fg_rgb[31:8], bg_rgb[55:32],
  // glyph_address[67:56], glyph_byte[75:68], zero fill[79:76]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gtr_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: operation[0]
  input  logic [0:0]                     in_tuser,
  // out_tdata, low bit up: pixel_x[9:0], pixel_y[19:10], luma_left[27:20],
  // chroma_blue[35:28], luma_right[43:36], chroma_red[51:44], zero fill[55:52]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gtr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gtr_pkg::*;

  localparam int PAIRS   = (GLYPH_WIDTH + 1) / 2;
  localparam int BPG     = (GLYPH_WIDTH * GLYPH_HEIGHT + 7) / 8;
  localparam bit ODD_W   = (GLYPH_WIDTH % 2) == 1;
  localparam int PX_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int PY_W    = $clog2(GLYPH_HEIGHT);
  localparam logic [PX_W-1:0] PX_LAST = PX_W'(PAIRS - 1);
  localparam logic [PY_W-1:0] PY_LAST = PY_W'(GLYPH_HEIGHT - 1);

  localparam logic [1:0] STEP_FG  = 2'd0;
  localparam logic [1:0] STEP_BG  = 2'd1;
  localparam logic [1:0] STEP_MID = 2'd2;

  // Input request fields
  logic                in_op;
  logic [7:0]          in_char;
  logic [23:0]         in_fg, in_bg;
  logic [STORE_AW-1:0] in_gaddr;
  logic [7:0]          in_gbyte;
  logic                in_acc;

  assign in_op    = in_tuser[0];
  assign in_char  = in_tdata[7:0];
  assign in_fg    = in_tdata[31:8];
  assign in_bg    = in_tdata[55:32];
  assign in_gaddr = in_tdata[67:56];
  assign in_gbyte = in_tdata[75:68];
  assign in_acc   = in_tvalid && in_tready;

  // Control state
  gtr_state_t      state_r, state_nxt;
  logic [COL_W-1:0] cur_col_r, cols_r;
  logic [ROW_W-1:0] cur_row_r, rows_r, rows_eff, row_inc;

  // Per-character working registers
  logic [7:0]          code_r;
  logic [23:0]         fg_r, bg_r;
  logic                nl_r;
  logic [ROW_W-1:0]    row_r;
  logic [1:0]          step_r;
  logic [XY_W-1:0]     x0_r, y0_r;
  logic [STORE_AW-1:0] base_r, rd_cnt_r;
  logic [PX_W-1:0]     px_r;
  logic [PY_W-1:0]     py_r;
  logic [7:0]          yfg_r, ybg_r, cbfg_r, crfg_r, cbbg_r, crbg_r, cbmid_r, crmid_r;
  logic [7:0]          code_mod;

  // Output register
  logic                out_tvalid_r;
  logic [XY_W-1:0]     out_x_r, out_y_r;
  logic [7:0]          out_yl_r, out_cb_r, out_yr_r, out_cr_r;
  logic                out_last_r;

  // Datapath nets
  logic [23:0]    mid_rgb, conv_rgb;
  gtr_ycc_t       conv;
  logic [7:0]     mem_rdata;
  logic           mem_rvalid;
  logic           fetch, consume, last_pair, need_one, fifo_clear;
  logic           bit_l, bit_r;
  gtr_fifo_stat_t fstat;

  assign rows_eff  = (rows_r == '0) ? ROW_W'(1) : rows_r;
  assign row_inc   = row_r + ROW_W'(1);
  assign code_mod  = ({1'b0, code_r} >= 9'(GLYPH_COUNT)) ? 8'(code_r - 8'(GLYPH_COUNT))
                                                         : code_r;

  assign last_pair = (px_r == PX_LAST) && (py_r == PY_LAST);
  assign need_one  = ODD_W && (px_r == PX_LAST);

  // Refill while the buffer plus the byte on its way fits one more byte.
  assign fetch = (state_r == ST_RUN) &&
                 ((6'(fstat.cnt) + (mem_rvalid ? 6'd8 : 6'd0)) <= 6'd8);

  // Advance one pair when the bits are there and the output register frees up.
  assign consume = (state_r == ST_RUN) &&
                   (fstat.cnt >= (need_one ? FIFO_CNT_W'(1) : FIFO_CNT_W'(2))) &&
                   (!out_tvalid_r || out_tready);

  // Right pixel of the last pair of an odd-width row lies outside: background.
  assign bit_l = fstat.head[1];
  assign bit_r = need_one ? 1'b0 : fstat.head[0];

  // Channel-wise average of foreground and background, for mixed pairs.
  assign mid_rgb = {8'((9'(fg_r[23:16]) + 9'(bg_r[23:16])) >> 1),
                    8'((9'(fg_r[15:8])  + 9'(bg_r[15:8]))  >> 1),
                    8'((9'(fg_r[7:0])   + 9'(bg_r[7:0]))   >> 1)};

  always_comb begin
    case (step_r)
      STEP_FG: conv_rgb = fg_r;
      STEP_BG: conv_rgb = bg_r;
      default: conv_rgb = mid_rgb;
    endcase
  end

  gtr_color_conv u_conv (
    .rgb (conv_rgb),
    .ycc (conv)
  );

  gtr_glyph_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (in_acc && (in_op == OP_LOAD)),
    .waddr  (in_gaddr),
    .wdata  (in_gbyte),
    .re     (fetch),
    .raddr  (base_r + rd_cnt_r),
    .rdata  (mem_rdata),
    .rvalid (mem_rvalid)
  );

  gtr_bit_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (fifo_clear),
    .push      (mem_rvalid),
    .push_byte (mem_rdata),
    .pop       (consume),
    .pop_two   (!need_one),
    .stat      (fstat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_DRAW)) begin
          if (in_char == CHAR_NL) begin
            state_nxt = ST_NORM;
          end else if ((in_char != CHAR_CR) && (cur_col_r < cols_r)) begin
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (row_r < rows_eff) begin
          state_nxt = nl_r ? ST_IDLE : ST_COLOR;
        end
      end
      ST_COLOR: begin
        if (step_r == STEP_MID) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (consume && last_pair) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    fifo_clear = (state_r == ST_COLOR) && (step_r == STEP_MID);
  end

  // Control registers: state, cursor, configuration, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      cols_r       <= COLUMNS_RST;
      rows_r       <= ROWS_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_COLUMNS: cols_r <= cfg_data;
          CFG_ROWS:    rows_r <= cfg_data[ROW_W-1:0];
        endcase
      end
      // carriage return: back to the first column
      if (in_acc && (in_op == OP_DRAW) && (in_char == CHAR_CR)) begin
        cur_col_r <= '0;
      end
      // newline: first column, next row with wrap
      if ((state_r == ST_NORM) && (row_r < rows_eff) && nl_r) begin
        cur_col_r <= '0;
        cur_row_r <= (row_inc == rows_eff) ? '0 : row_inc;
      end
      if (consume && last_pair) begin
        cur_col_r <= cur_col_r + COL_W'(1);
      end
      if (consume) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= in_char;
      fg_r   <= in_fg;
      bg_r   <= in_bg;
      nl_r   <= (in_char == CHAR_NL);
      row_r  <= cur_row_r;
    end

    if (state_r == ST_NORM) begin
      // reduce the row modulo the row count, one subtraction a cycle
      if (row_r >= rows_eff) begin
        row_r <= row_r - rows_eff;
      end
      x0_r   <= XY_W'(int'(cur_col_r) * GLYPH_WIDTH + GLYPH_WIDTH / 2);
      y0_r   <= XY_W'(int'(row_r) * GLYPH_HEIGHT + GLYPH_HEIGHT / 2);
      base_r <= STORE_AW'(int'(code_mod) * BPG);
      step_r <= STEP_FG;
    end

    if (state_r == ST_COLOR) begin
      case (step_r)
        STEP_FG: begin
          yfg_r  <= conv.y;
          cbfg_r <= conv.cb;
          crfg_r <= conv.cr;
        end
        STEP_BG: begin
          ybg_r  <= conv.y;
          cbbg_r <= conv.cb;
          crbg_r <= conv.cr;
        end
        default: begin
          cbmid_r  <= conv.cb;
          crmid_r  <= conv.cr;
          rd_cnt_r <= '0;
          px_r     <= '0;
          py_r     <= '0;
        end
      endcase
      step_r <= step_r + 2'd1;
    end

    if (fetch) begin
      rd_cnt_r <= rd_cnt_r + STORE_AW'(1);
    end

    if (consume) begin
      if (px_r == PX_LAST) begin
        px_r <= '0;
        py_r <= py_r + PY_W'(1);
      end else begin
        px_r <= px_r + PX_W'(1);
      end
      out_x_r    <= x0_r + (XY_W'(px_r) << 1);
      out_y_r    <= y0_r + XY_W'(py_r);
      out_yl_r   <= bit_l ? yfg_r : ybg_r;
      out_yr_r   <= bit_r ? yfg_r : ybg_r;
      out_cb_r   <= (bit_l && bit_r) ? cbfg_r : ((!bit_l && !bit_r) ? cbbg_r : cbmid_r);
      out_cr_r   <= (bit_l && bit_r) ? crfg_r : ((!bit_l && !bit_r) ? crbg_r : crmid_r);
      out_last_r <= last_pair;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'h0, out_cr_r, out_yr_r, out_cb_r, out_yl_r, out_y_r, out_x_r};

endmodule

// File: src/gtr_glyph_mem.sv
module gtr_glyph_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  logic [gtr_pkg::STORE_AW-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [gtr_pkg::STORE_AW-1:0] raddr,
  output logic [7:0]                   rdata,
  output logic                         rvalid
);
  import gtr_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;
  logic       rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= re;
    end
  end

  assign rdata  = rdata_r;
  assign rvalid = rvalid_r;

endmodule

// File: src/gtr_bit_fifo.sv
module gtr_bit_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clear,
  input  logic                    push,
  input  logic [7:0]              push_byte,
  input  logic                    pop,
  input  logic                    pop_two,
  output gtr_pkg::gtr_fifo_stat_t stat
);
  import gtr_pkg::*;

  logic [FIFO_W-1:0]     bits_r, bits_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIFO_CNT_W-1:0] rem;
  logic [FIFO_W-1:0]     shifted;

  // Bits sit MSB-aligned; the next pixel is always the top bit.
  always_comb begin
    rem     = cnt_r;
    shifted = bits_r;
    if (pop) begin
      if (pop_two) begin
        rem     = cnt_r - FIFO_CNT_W'(2);
        shifted = bits_r << 2;
      end else begin
        rem     = cnt_r - FIFO_CNT_W'(1);
        shifted = bits_r << 1;
      end
    end
    bits_nxt = shifted;
    cnt_nxt  = rem;
    if (push) begin
      bits_nxt = shifted | ({push_byte, 8'h00} >> rem);
      cnt_nxt  = rem + FIFO_CNT_W'(8);
    end
    if (clear) begin
      bits_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

  assign stat.cnt  = cnt_r;
  assign stat.head = bits_r[FIFO_W-1 -: 2];

endmodule

// File: src/gtr_color_conv.sv
module gtr_color_conv (
  input  logic [23:0]       rgb,
  output gtr_pkg::gtr_ycc_t ycc
);
  import gtr_pkg::*;

  logic [15:0] r, g, b;
  logic [15:0] y_sum, cb_sum, cr_sum;

  assign r = 16'(rgb[23:16]);
  assign g = 16'(rgb[15:8]);
  assign b = 16'(rgb[7:0]);

  // Chroma sums stay within 0..65535 with the bias, so 16-bit wrap is exact.
  assign y_sum  = r * Y_R + g * Y_G + b * Y_B;
  assign cb_sum = C_BIAS + b * CB_B - r * CB_R - g * CB_G;
  assign cr_sum = C_BIAS + r * CR_R - g * CR_G - b * CR_B;

  assign ycc.y  = y_sum[15:8] + Y_OFS;
  assign ycc.cb = cb_sum[15:8];
  assign ycc.cr = cr_sum[15:8];

endmodule

// File: src/gtr_checker.sv
`include "assert_macros.svh"

module gtr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gtr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import gtr_pkg::*;

  // Stalled result holds its payload.
  `CHK_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Reset leaves no result pending and the input open.
  `CHK_ALWAYS(a_reset_clean, !rst_n |=> !out_tvalid && in_tready, "bad state after reset")

  // While a character is still being drawn, no new request enters.
  `CHK_RUN(a_busy_mid_glyph, out_tvalid && !out_tlast |-> !in_tready, "request open mid glyph")

  // A glyph store load completes in the cycle it is taken.
  `CHK_RUN(a_load_single, in_tvalid && in_tready && (in_tuser[0] == OP_LOAD) |=> in_tready, "load stalled input")

endmodule

bind glyph_to_ycbcr_renderer gtr_checker u_gtr_checker (.*);

// File: verif/testbench.sv
module testbench;
  import gtr_pkg::*;

  localparam int GLYPH_W       = 8;
  localparam int GLYPH_H       = 16;
  localparam int GLYPH_BYTES   = (GLYPH_W * GLYPH_H + 7) / 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 600;        // pixel pairs seen before the long hold-off
  localparam int DIRECTED_ROWS = 24;

  // One pixel-pair write as the block should emit it.
  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [7:0]      luma_l;
    logic [7:0]      cb;
    logic [7:0]      luma_r;
    logic [7:0]      cr;
    logic            last;
  } pixel_pair_t;

  // One request of the directed part. Rows with flat set carry the luma and
  // chroma that every pair of the drawn character must show.
  typedef struct packed {
    logic        op;
    logic [7:0]  code;
    logic [23:0] fg;
    logic [23:0] bg;
    logic [11:0] addr;
    logic [7:0]  gbyte;
    logic        flat;
    logic [7:0]  flat_y;
    logic [7:0]  flat_cb;
    logic [7:0]  flat_cr;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  glyph_to_ycbcr_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Own copy of the console: glyph store, cursor and geometry registers.
  logic [7:0]       glyph_mem     [STORE_DEPTH];
  bit               glyph_written [STORE_DEPTH];
  bit               glyph_ready   [256];
  int               ready_codes   [$];
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] col_limit;
  logic [ROW_W-1:0] row_limit;

  pixel_pair_t pending_pairs [$];

  // Typed-in colors for the flat rows of the directed part.
  bit         flat_on;
  logic [7:0] flat_y, flat_cb, flat_cr;

  int  errors;
  int  pairs_seen;
  int  cycles;
  int  requests_sent;
  bit  idle_on;

  // Glyph of character 255 sits at the top of the store, so the last store addresses and the
  // all-ones code are touched early; the final row writes the first store address.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF0, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF1, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF2, 8'hAA, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF3, 8'h55, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF4, 8'h81, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF5, 8'h7E, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF6, 8'hF0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF7, 8'h0F, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF8, 8'hC3, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFF9, 8'h3C, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFFA, 8'h01, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFFB, 8'h80, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFFC, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFFD, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFFE, 8'h18, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'hFFF, 8'hE7, 1'b0, 8'd0, 8'd0, 8'd0},
    // white on white and black on black: every pair reads flat
    '{OP_DRAW, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 12'h0, 8'h0, 1'b1, 8'd235, 8'd128, 8'd128},
    '{OP_DRAW, 8'hFF, 24'h000000, 24'h000000, 12'h0, 8'h0, 1'b1, 8'd16, 8'd128, 8'd128},
    '{OP_DRAW, 8'hFF, 24'hFFFFFF, 24'h000000, 12'h0, 8'h0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_DRAW, CHAR_CR, 24'h0, 24'h0, 12'h0, 8'h0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_DRAW, 8'hFF, 24'hFF0000, 24'h0000FF, 12'h0, 8'h0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_DRAW, CHAR_NL, 24'h0, 24'h0, 12'h0, 8'h0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_DRAW, 8'hFF, 24'h00FF00, 24'hFF00FF, 12'h0, 8'h0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OP_LOAD, 8'h00, 24'h0, 24'h0, 12'h000, 8'h5A, 1'b0, 8'd0, 8'd0, 8'd0}
  };

  // Y of one pixel, Q8 coefficients, floored, offset 16.
  function automatic logic [7:0] luma_of(int r, int g, int b);
    return 8'(((66 * r + 129 * g + 25 * b) >> 8) + 16);
  endfunction

  // Cb and Cr are biased by 128*256 first, so the shift never sees a negative sum.
  function automatic logic [7:0] chroma_blue_of(int r, int g, int b);
    int s;
    s = -38 * r - 74 * g + 112 * b + 32768;
    return 8'(s >> 8);
  endfunction

  function automatic logic [7:0] chroma_red_of(int r, int g, int b);
    int s;
    s = 112 * r - 94 * g - 18 * b + 32768;
    return 8'(s >> 8);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_request(logic [7:0] code, logic [23:0] fg,
      logic [23:0] bg, logic [11:0] addr, logic [7:0] gbyte);
    return {4'b0, gbyte, addr, bg, fg, code};
  endfunction

  function automatic int row_count();
    return (row_limit == 0) ? 1 : int'(row_limit);
  endfunction

  // Walk the glyph of code at the cursor and queue one pair per two columns per row.
  function automatic void render_glyph(logic [7:0] code, logic [23:0] fg, logic [23:0] bg);
    int          row, base, r0, g0, b0, r1, g1, b1;
    logic [7:0]  bits;
    logic [23:0] c0, c1;
    pixel_pair_t p;
    row  = int'(cursor_row) % row_count();
    base = int'(code) * GLYPH_BYTES;
    for (int y = 0; y < GLYPH_H; y++) begin
      bits = glyph_mem[base + y];
      for (int x = 0; x < GLYPH_W; x += 2) begin
        c0 = bits[7 - x] ? fg : bg;
        c1 = bits[6 - x] ? fg : bg;
        r0 = c0[23:16]; g0 = c0[15:8]; b0 = c0[7:0];
        r1 = c1[23:16]; g1 = c1[15:8]; b1 = c1[7:0];
        p.x      = XY_W'(int'(cursor_col) * GLYPH_W + GLYPH_W / 2 + x);
        p.y      = XY_W'(row * GLYPH_H + GLYPH_H / 2 + y);
        p.luma_l = luma_of(r0, g0, b0);
        p.luma_r = luma_of(r1, g1, b1);
        p.cb     = chroma_blue_of((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2);
        p.cr     = chroma_red_of((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2);
        p.last   = (y == GLYPH_H - 1) && (x + 2 >= GLYPH_W);
        if (flat_on) begin
          p.luma_l = flat_y;
          p.luma_r = flat_y;
          p.cb     = flat_cb;
          p.cr     = flat_cr;
        end
        pending_pairs.push_back(p);
      end
    end
    cursor_col = cursor_col + 1'b1;
  endfunction

  // Advance the console by one accepted request.
  function automatic void console_step(logic op, logic [IN_TDATA_W-1:0] data);
    logic [7:0]  code;
    logic [11:0] addr;
    logic [7:0]  ch;
    bit          full;
    code = data[7:0];
    addr = data[67:56];
    if (op == OP_LOAD) begin
      glyph_mem[addr]     = data[75:68];
      glyph_written[addr] = 1'b1;
      ch   = addr[11:4];
      full = 1'b1;
      for (int i = 0; i < GLYPH_BYTES; i++)
        if (!glyph_written[{ch, i[3:0]}]) full = 1'b0;
      if (full && !glyph_ready[ch]) begin
        glyph_ready[ch] = 1'b1;
        ready_codes.push_back(ch);
      end
    end else if (code == CHAR_NL) begin
      cursor_row = ROW_W'((int'(cursor_row) % row_count() + 1) % row_count());
      cursor_col = '0;
    end else if (code == CHAR_CR) begin
      cursor_col = '0;
    end else if (cursor_col < col_limit) begin
      render_glyph(code, data[31:8], data[55:32]);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Offer one request, hold it until accepted, then advance the console copy.
  task automatic send_request(logic op, logic [IN_TDATA_W-1:0] data);
    if (idle_on && (requests_sent / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = data;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    console_step(op, data);
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop valid, let every expected pair drain, then let a trailing glyph walk finish.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rows);
    cfg_index = CFG_COLUMNS;
    cfg_data  = cols;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    col_limit = cols[COL_W-1:0];
    @(negedge clk);
    cfg_index = CFG_ROWS;
    cfg_data  = rows;
    do @(posedge clk); while (!cfg_ready);
    row_limit = rows[ROW_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random traffic: whole glyph loads, stray store writes, cursor moves and draws.
  task automatic run_console(int n_requests);
    int          sent, pick;
    logic [7:0]  code;
    logic [23:0] fg, bg;
    sent = 0;
    while (sent < n_requests) begin
      pick = $urandom_range(0, 99);
      fg   = 24'($urandom);
      bg   = ($urandom_range(0, 3) == 0) ? fg : 24'($urandom);
      code = 8'($urandom_range(0, 255));
      if (pick < 12) begin
        for (int i = 0; i < GLYPH_BYTES; i++)
          send_request(OP_LOAD, pack_request(8'($urandom), 24'($urandom), 24'($urandom),
                                             {code, i[3:0]}, 8'($urandom)));
        sent += GLYPH_BYTES;
      end else begin
        if (pick < 17) begin
          send_request(OP_LOAD, pack_request(code, fg, bg, 12'($urandom), 8'($urandom)));
        end else begin
          if (pick < 25) code = CHAR_NL;
          else if (pick < 30) code = CHAR_CR;
          // a character that would be drawn must have its whole glyph in the store
          else if (code != CHAR_NL && code != CHAR_CR && cursor_col < col_limit &&
                   !glyph_ready[code])
            code = 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
          send_request(OP_DRAW, pack_request(code, fg, bg, 12'($urandom), 8'($urandom)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, quiet stretches, and one long hold-off
  // that backs the block up into its input.
  initial begin : receiver
    int stall_left, hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (!hold_done && pairs_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (idle_on && (cycles / 512) % 4 != 3 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Compare every accepted pixel pair with the oldest one still expected.
  always @(posedge clk) begin
    pixel_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pairs.size() == 0) begin
        $error("pixel pair with none expected: x %0d, y %0d", out_tdata[9:0], out_tdata[19:10]);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("pixel_x", want.x, out_tdata[9:0]);
        check_field("pixel_y", want.y, out_tdata[19:10]);
        check_field("luma_left", want.luma_l, out_tdata[27:20]);
        check_field("chroma_blue", want.cb, out_tdata[35:28]);
        check_field("luma_right", want.luma_r, out_tdata[43:36]);
        check_field("chroma_red", want.cr, out_tdata[51:44]);
        check_field("last_of_glyph", want.last, out_tlast);
        pairs_seen++;
      end
    end
  end

  initial begin : stimulus
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    idle_on   = 1'b1;
    flat_on   = 1'b0;
    cursor_col = '0;
    cursor_row = '0;
    col_limit  = COLUMNS_RST;
    row_limit  = ROWS_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset geometry.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      flat_on = directed_rows[i].flat;
      flat_y  = directed_rows[i].flat_y;
      flat_cb = directed_rows[i].flat_cb;
      flat_cr = directed_rows[i].flat_cr;
      send_request(directed_rows[i].op,
                   pack_request(directed_rows[i].code, directed_rows[i].fg, directed_rows[i].bg,
                                directed_rows[i].addr, directed_rows[i].gbyte));
    end
    flat_on = 1'b0;

    // Widest screen; the long hold-off falls in here.
    wait_idle();
    set_geometry(7'd127, 7'd62);
    run_console(110);

    // One cell: the second character on a line is dropped, rows fold to zero.
    wait_idle();
    set_geometry(7'd1, 7'd1);
    run_console(80);

    // Zero columns drop everything; zero rows act as one.
    wait_idle();
    set_geometry(7'd0, 7'd0);
    run_console(20);

    // Bit 6 of the row write falls outside the 6-bit register.
    wait_idle();
    set_geometry(7'd10, 7'd69);
    run_console(90);

    wait_idle();
    set_geometry(7'd100, 7'd63);
    run_console(100);

    // Back to the power-up geometry, both sides at full rate.
    wait_idle();
    set_geometry(COLUMNS_RST, 7'(ROWS_RST));
    idle_on = 1'b0;
    run_console(100);

    in_tvalid = 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/gtr_pkg.sv
src/gtr_glyph_mem.sv
src/gtr_bit_fifo.sv
src/gtr_color_conv.sv
src/glyph_to_ycbcr_renderer.sv
src/gtr_checker.sv
verif/testbench.sv
